/* src/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int WIN_W            = 7;
  localparam int DEF_WINDOW_DEPTH = 64;

  localparam logic [WIN_W-1:0] WIN_RESET = 7'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       last_sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] window_max;
    logic                       stream_end;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic pop_front;
    logic load_front;
    logic pop_back;
    logic load_back;
    logic push;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic front_old;
    logic back_le;
    logic multi;
    logic emit;
    logic out_free;
  } sts_t;

endpackage

/* src/swm_ram.sv */
// ----------------------------------------------------------------------------
// swm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swm_ram import swm_pkg::*; #(
  parameter int WIDTH = SAMPLE_W,
  parameter int DEPTH = DEF_WINDOW_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/swm_ctrl.sv */
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer: front expiry pops, back pops, push, then result hand-off.
// ----------------------------------------------------------------------------
module swm_ctrl import swm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FRONT = 3'd1;
  localparam logic [2:0] S_FRD   = 3'd2;
  localparam logic [2:0] S_BACK  = 3'd3;
  localparam logic [2:0] S_BRD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_FRONT;
        end
      end
      S_FRONT: begin
        if (sts.front_old) begin
          cmd.pop_front = 1'b1;
          // with one entry left the deque just empties, nothing to fetch
          state_nxt     = sts.multi ? S_FRD : S_FRONT;
        end else begin
          state_nxt = S_BACK;
        end
      end
      S_FRD: begin
        cmd.load_front = 1'b1;
        state_nxt      = S_FRONT;
      end
      S_BACK: begin
        if (sts.back_le) begin
          cmd.pop_back = 1'b1;
          state_nxt    = sts.multi ? S_BRD : S_BACK;
        end else begin
          cmd.push  = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_BRD: begin
        cmd.load_back = 1'b1;
        state_nxt     = S_BACK;
      end
      S_OUT: begin
        if (!sts.emit) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/swm_dp.sv */
// ----------------------------------------------------------------------------
// swm_dp
// Deque datapath: head/count/position registers, cached front and back
// entries, deque RAM, window register and output register.
// ----------------------------------------------------------------------------
module swm_dp import swm_pkg::*; #(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [WIN_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output sts_t             sts
);

  localparam int AW      = $clog2(WINDOW_DEPTH);
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int POS_MOD = 4 * WINDOW_DEPTH;
  localparam int PW      = $clog2(POS_MOD);
  localparam int CW      = (PW > WIN_W) ? PW : WIN_W;
  localparam int KCAP    = (WINDOW_DEPTH < 127) ? WINDOW_DEPTH : 127;
  localparam int MEM_W   = PW + SAMPLE_W;

  logic [WIN_W-1:0]           win_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic                       last_r;
  logic [AW-1:0]              head_r;
  logic [CNT_W-1:0]           count_r;
  logic [PW-1:0]              pos_r;
  logic [WIN_W-1:0]           seen_r;
  logic signed [SAMPLE_W-1:0] front_val_r;
  logic [PW-1:0]              front_pos_r;
  logic signed [SAMPLE_W-1:0] back_val_r;
  logic signed [SAMPLE_W-1:0] best_r;
  logic                       emit_r;
  logic                       out_valid_r;
  out_t                       out_data_r;

  logic [WIN_W-1:0]           k;
  logic [PW:0]                diff;
  logic [PW-1:0]              age;
  logic [SUM_W-1:0]           inc_sum;
  logic [SUM_W-1:0]           back_sum;
  logic [SUM_W-1:0]           push_sum;
  logic [AW-1:0]              head_nxt;
  logic [AW-1:0]              back_slot;
  logic [AW-1:0]              push_slot;
  logic [PW-1:0]              pos_nxt;
  logic [WIN_W-1:0]           seen_nxt;
  logic [MEM_W-1:0]           rdata;
  logic signed [SAMPLE_W-1:0] rd_val;
  logic [PW-1:0]              rd_pos;
  logic                       empty;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign empty     = (count_r == '0);

  // effective window: zero means one, capped at the deque depth
  always_comb begin
    if (win_r == '0) begin
      k = WIN_W'(1);
    end else if (int'(win_r) > KCAP) begin
      k = WIN_W'(KCAP);
    end else begin
      k = win_r;
    end
  end

  // age of the front entry, positions wrap modulo POS_MOD
  assign diff = {1'b0, pos_r} - {1'b0, front_pos_r};
  assign age  = diff[PW] ? PW'(diff + (PW+1)'(POS_MOD)) : diff[PW-1:0];

  assign inc_sum  = SUM_W'(head_r) + SUM_W'(1);
  assign back_sum = SUM_W'(head_r) + SUM_W'(count_r) - SUM_W'(2);
  assign push_sum = SUM_W'(head_r) + SUM_W'(count_r);

  assign head_nxt  = (inc_sum >= SUM_W'(WINDOW_DEPTH)) ?
                     AW'(inc_sum - SUM_W'(WINDOW_DEPTH)) : AW'(inc_sum);
  assign back_slot = (back_sum >= SUM_W'(WINDOW_DEPTH)) ?
                     AW'(back_sum - SUM_W'(WINDOW_DEPTH)) : AW'(back_sum);
  assign push_slot = (push_sum >= SUM_W'(WINDOW_DEPTH)) ?
                     AW'(push_sum - SUM_W'(WINDOW_DEPTH)) : AW'(push_sum);

  assign pos_nxt  = (pos_r == PW'(POS_MOD - 1)) ? '0 : pos_r + PW'(1);
  assign seen_nxt = (seen_r < k) ? seen_r + WIN_W'(1) : seen_r;

  assign rd_val = signed'(rdata[SAMPLE_W-1:0]);
  assign rd_pos = rdata[SAMPLE_W +: PW];

  assign sts.front_old = !empty && (CW'(age) >= CW'(k));
  assign sts.back_le   = !empty && (back_val_r <= x_r);
  assign sts.multi     = (count_r > CNT_W'(1));
  assign sts.emit      = emit_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  swm_ram #(
    .WIDTH (MEM_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (push_slot),
    .wdata ({pos_r, x_r}),
    .raddr (cmd.pop_back ? back_slot : head_nxt),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WIN_RESET;
      head_r      <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        win_r <= cfg_data;
      end
      if (cmd.pop_front) begin
        head_r  <= head_nxt;
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.pop_back) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.push) begin
        if (last_r) begin
          // end of stream: deque and counters start over
          head_r  <= '0;
          count_r <= '0;
          pos_r   <= '0;
          seen_r  <= '0;
        end else begin
          count_r <= count_r + CNT_W'(1);
          pos_r   <= pos_nxt;
          seen_r  <= seen_nxt;
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r    <= in_data.sample_value;
      last_r <= in_data.last_sample;
    end
    if (cmd.load_front) begin
      front_val_r <= rd_val;
      front_pos_r <= rd_pos;
    end
    if (cmd.load_back) begin
      back_val_r <= rd_val;
    end
    if (cmd.push) begin
      back_val_r <= x_r;
      if (empty) begin
        front_val_r <= x_r;
        front_pos_r <= pos_r;
      end
      best_r <= empty ? x_r : front_val_r;
      emit_r <= last_r || (seen_nxt >= k);
    end
    if (cmd.load_out) begin
      out_data_r.window_max <= best_r;
      out_data_r.stream_end <= last_r;
    end
  end

endmodule

/* src/sliding_window_maximum.sv */
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Each input beat is loaded in IDLE, pops expired front entries in FRONT/FRD,
// pops back entries not above it in BACK/BRD, is pushed, and, if a result is
// emitted, waits in OUT for the previous result to leave. A new sample is taken
// only in IDLE; each entry is popped at most once, so pops average at most one per sample.
// Reset (rst_n, synchronous): deque empty, counters zero, window size 3.
// ----------------------------------------------------------------------------
module sliding_window_maximum import swm_pkg::*; #(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [WIN_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swm_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
